/* hdl/ekvs_pkg.sv */
// shared types, constants and functions of the encrypted key-value store
`timescale 1ns / 1ps
package ekvs_pkg;

    localparam int ENTRIES     = 8;
    localparam int SLOT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_CHARS   = 8;
    localparam int VALUE_BYTES = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [31:0] FNV_BASIS = 32'h811c_9dc5;
    localparam int          CK_BYTES  = 16;

    typedef enum logic [2:0] {
        KIND_SET    = 3'd0,
        KIND_GET    = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_HAS    = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_e_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NOSPACE  = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    localparam logic CFG_CK_LOW  = 1'b0;
    localparam logic CFG_CK_HIGH = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] key_text;
        logic [63:0] value_in;
        logic [3:0]  value_length;
        logic [3:0]  capacity;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [63:0] value_out;
        logic [3:0]  out_length;
    } rsp_t;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        OP_REPLY,
        OP_WRITE,
        OP_READ,
        OP_ERASE,
        OP_WIPE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [SLOT_W-1:0] slot;
        logic [63:0] key;
        logic [63:0] data;
        logic [3:0]  len;
        logic [1:0]  status;
        logic        found;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CRYPT,
        BK_DONE
    } back_state_t;

    // one fnv-1a round
    function automatic logic [31:0] fnv_round(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

/* hdl/ekvs_front.sv */
// front end: key trimming, slot lookup and request classification
`timescale 1ns / 1ps
module ekvs_front
(
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ekvs_pkg::req_t               in_data,
    input  logic [ekvs_pkg::ENTRIES-1:0] slot_used,
    input  logic [63:0]                  slot_key [ekvs_pkg::ENTRIES],
    input  logic [3:0]                   slot_length [ekvs_pkg::ENTRIES],
    input  logic                         hazard,
    output logic                         cmd_valid,
    input  logic                         cmd_ready,
    output ekvs_pkg::cmd_t               cmd_data
);

    logic [63:0]                  key;
    logic                         key_ok;
    logic                         hit;
    logic [ekvs_pkg::SLOT_W-1:0]  hit_slot;
    logic                         has_free;
    logic [ekvs_pkg::SLOT_W-1:0]  free_slot;
    logic                         stop;

    // trim at the first zero byte
    always_comb
    begin
        key  = '0;
        stop = 1'b0;
        for (int n = 0; n < 8; n++)
        begin
            if (in_data.key_text[8*n +: 8] == 8'd0)
                stop = 1'b1;
            if (!stop)
                key[8*n +: 8] = in_data.key_text[8*n +: 8];
        end
        key_ok = 1'b1;
        for (int n = ekvs_pkg::KEY_CHARS; n < 8; n++)
            if (key[8*n +: 8] != 8'd0)
                key_ok = 1'b0;
    end

    // lookup of match and lowest free slot
    always_comb
    begin
        hit       = 1'b0;
        hit_slot  = '0;
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = ekvs_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (slot_used[i] && slot_key[i] == key)
            begin
                hit      = key_ok;
                hit_slot = ekvs_pkg::SLOT_W'(i);
            end
            if (!slot_used[i])
            begin
                has_free  = 1'b1;
                free_slot = ekvs_pkg::SLOT_W'(i);
            end
        end
    end

    // classify the word; stalls while the queue holds a command or the back end is busy
    assign cmd_valid = in_valid && !hazard;
    assign in_ready  = cmd_ready && !hazard;

    always_comb
    begin
        cmd_data        = '0;
        cmd_data.op     = ekvs_pkg::OP_REPLY;
        cmd_data.status = ekvs_pkg::ST_OK;
        cmd_data.key    = key;
        cmd_data.data   = in_data.value_in;
        cmd_data.slot   = hit ? hit_slot : free_slot;
        unique case (in_data.kind)
            ekvs_pkg::KIND_SET:
            begin
                cmd_data.len = in_data.value_length;
                if (in_data.value_length == 4'd0 || (in_data.value_length
                        <= 4'(ekvs_pkg::VALUE_BYTES) && !key_ok))
                    cmd_data.status = ekvs_pkg::ST_INVALID;
                else if (in_data.value_length > 4'(ekvs_pkg::VALUE_BYTES))
                    cmd_data.status = ekvs_pkg::ST_NOSPACE;
                else if (!hit && !has_free)
                    cmd_data.status = ekvs_pkg::ST_NOSPACE;
                else
                    cmd_data.op = ekvs_pkg::OP_WRITE;
            end
            ekvs_pkg::KIND_GET:
            begin
                cmd_data.len = slot_length[hit_slot];
                if (in_data.capacity == 4'd0)
                    cmd_data.status = ekvs_pkg::ST_INVALID;
                else if (!hit)
                    cmd_data.status = ekvs_pkg::ST_NOTFOUND;
                else if (slot_length[hit_slot] > in_data.capacity)
                    cmd_data.status = ekvs_pkg::ST_NOSPACE;
                else
                    cmd_data.op = ekvs_pkg::OP_READ;
            end
            ekvs_pkg::KIND_REMOVE:
            begin
                if (!hit)
                    cmd_data.status = ekvs_pkg::ST_NOTFOUND;
                else
                    cmd_data.op = ekvs_pkg::OP_ERASE;
            end
            ekvs_pkg::KIND_HAS:
                cmd_data.found = hit;
            ekvs_pkg::KIND_CLEAR:
                cmd_data.op = ekvs_pkg::OP_WIPE;
            default:
                cmd_data.status = ekvs_pkg::ST_INVALID;
        endcase
    end

endmodule

/* hdl/ekvs_queue.sv */
// short command queue between front and back
`timescale 1ns / 1ps
module ekvs_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  ekvs_pkg::cmd_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output ekvs_pkg::cmd_t rd_data,
    output logic           not_empty
);

    ekvs_pkg::cmd_t mem_reg [ekvs_pkg::QUEUE_DEPTH];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;

    assign push      = wr_valid && wr_ready;
    assign pop       = rd_valid && rd_ready;
    assign wr_ready  = cnt_reg != 2'(ekvs_pkg::QUEUE_DEPTH);
    assign rd_valid  = cnt_reg != 2'd0;
    assign not_empty = rd_valid;
    assign rd_data   = mem_reg[rp_reg];

    // pointer update
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'(ekvs_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue push lost");

endmodule

/* hdl/ekvs_back.sv */
// back end: slot store, keystream unit and result register
`timescale 1ns / 1ps
module ekvs_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [63:0]                  cfg_data,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  ekvs_pkg::cmd_t               cmd_data,
    output logic [ekvs_pkg::ENTRIES-1:0] slot_used,
    output logic [63:0]                  slot_key [ekvs_pkg::ENTRIES],
    output logic [3:0]                   slot_length [ekvs_pkg::ENTRIES],
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ekvs_pkg::rsp_t               out_data
);

    logic [63:0] ck_low_reg, ck_high_reg;
    logic [ekvs_pkg::ENTRIES-1:0] used_reg, used_next;
    logic [63:0] key_reg    [ekvs_pkg::ENTRIES];
    logic [63:0] cipher_reg [ekvs_pkg::ENTRIES];
    logic [3:0]  len_reg    [ekvs_pkg::ENTRIES];

    ekvs_pkg::back_state_t state_reg, state_next;
    ekvs_pkg::cmd_t        cur_reg, cur_next;
    logic [2:0]  byte_reg, byte_next;
    logic [3:0]  rnd_reg, rnd_next;
    logic [31:0] h_reg, h_next;
    logic [63:0] acc_reg, acc_next;
    logic        ov_reg, ov_next;
    ekvs_pkg::rsp_t rsp_reg, rsp_next;
    logic        take, commit;
    logic [63:0] src_word;
    logic [7:0]  ks;
    logic [7:0]  ck_byte;

    assign cfg_ready   = 1'b1;
    assign slot_used   = used_reg;
    assign slot_key    = key_reg;
    assign slot_length = len_reg;
    assign out_valid   = ov_reg;
    assign out_data    = rsp_reg;
    assign cmd_ready   = state_reg == ekvs_pkg::BK_IDLE && (!ov_reg || out_ready);
    assign take        = cmd_valid && cmd_ready;
    assign busy        = state_reg != ekvs_pkg::BK_IDLE;

    // keystream round inputs
    assign src_word = (cur_reg.op == ekvs_pkg::OP_READ) ? cipher_reg[cur_reg.slot] : cur_reg.data;
    assign ck_byte  = rnd_reg[3] ? ck_high_reg[8*rnd_reg[2:0] +: 8] : ck_low_reg[8*rnd_reg[2:0] +: 8];
    assign ks       = h_reg[7:0] ^ h_reg[15:8];

    // sequencer: per byte, one fnv round per cycle, then an xor step
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        byte_next  = byte_reg;
        rnd_next   = rnd_reg;
        h_next     = h_reg;
        acc_next   = acc_reg;
        ov_next    = ov_reg && !out_ready;
        rsp_next   = rsp_reg;
        commit     = 1'b0;
        unique case (state_reg)
            ekvs_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    cur_next  = cmd_data;
                    byte_next = 3'd0;
                    rnd_next  = 4'd0;
                    acc_next  = '0;
                    h_next    = ekvs_pkg::FNV_BASIS ^ {8'd0, 8'(cmd_data.slot), 16'd0};
                    if (cmd_data.op == ekvs_pkg::OP_WRITE || cmd_data.op == ekvs_pkg::OP_READ)
                        state_next = ekvs_pkg::BK_CRYPT;
                    else
                        state_next = ekvs_pkg::BK_DONE;
                end
            end
            ekvs_pkg::BK_CRYPT:
            begin
                if (rnd_reg == 4'(ekvs_pkg::CK_BYTES - 1))
                begin
                    h_next   = ekvs_pkg::fnv_round(h_reg, ck_byte);
                    rnd_next = 4'd0;
                    state_next = ekvs_pkg::BK_CRYPT;
                    byte_next  = byte_reg;
                    // mark final round done by using ov-independent flag: h now ready
                    cur_next.found = 1'b1;
                end
                else if (cur_reg.found)
                begin
                    // apply keystream byte
                    acc_next[8*byte_reg +: 8] = src_word[8*byte_reg +: 8] ^ ks;
                    cur_next.found = 1'b0;
                    if ({1'b0, byte_reg} == cur_reg.len - 4'd1)
                        state_next = ekvs_pkg::BK_DONE;
                    else
                    begin
                        byte_next = byte_reg + 3'd1;
                        h_next    = ekvs_pkg::FNV_BASIS
                            ^ {8'd0, 8'(cur_reg.slot), 13'd0, byte_reg + 3'd1};
                    end
                end
                else
                begin
                    h_next   = ekvs_pkg::fnv_round(h_reg, ck_byte);
                    rnd_next = rnd_reg + 4'd1;
                end
            end
            ekvs_pkg::BK_DONE:
            begin
                commit     = 1'b1;
                state_next = ekvs_pkg::BK_IDLE;
                ov_next    = 1'b1;
                rsp_next   = '0;
                rsp_next.status = cur_reg.status;
                rsp_next.found  = (cur_reg.op == ekvs_pkg::OP_REPLY) && cur_reg.found;
                if (cur_reg.op == ekvs_pkg::OP_READ)
                begin
                    rsp_next.value_out  = acc_reg;
                    rsp_next.out_length = cur_reg.len;
                end
            end
            default:
                state_next = ekvs_pkg::BK_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ekvs_pkg::BK_IDLE;
            ov_reg      <= 1'b0;
            used_reg    <= '0;
            ck_low_reg  <= '0;
            ck_high_reg <= '0;
            cur_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cur_reg   <= cur_next;
            if (cfg_valid && cfg_index == ekvs_pkg::CFG_CK_LOW)
                ck_low_reg <= cfg_data;
            if (cfg_valid && cfg_index == ekvs_pkg::CFG_CK_HIGH)
                ck_high_reg <= cfg_data;
            if (commit)
            begin
                unique case (cur_reg.op)
                    ekvs_pkg::OP_WRITE: used_reg[cur_reg.slot] <= 1'b1;
                    ekvs_pkg::OP_ERASE: used_reg[cur_reg.slot] <= 1'b0;
                    ekvs_pkg::OP_WIPE:  used_reg <= '0;
                    default: used_reg <= used_reg;
                endcase
            end
        end
    end

    // datapath and slot payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        rnd_reg  <= rnd_next;
        h_reg    <= h_next;
        acc_reg  <= acc_next;
        rsp_reg  <= rsp_next;
        if (commit && cur_reg.op == ekvs_pkg::OP_WRITE)
        begin
            key_reg[cur_reg.slot]    <= cur_reg.key;
            cipher_reg[cur_reg.slot] <= acc_reg;
            len_reg[cur_reg.slot]    <= cur_reg.len;
        end
        if (commit && cur_reg.op == ekvs_pkg::OP_ERASE)
        begin
            key_reg[cur_reg.slot]    <= '0;
            cipher_reg[cur_reg.slot] <= '0;
            len_reg[cur_reg.slot]    <= '0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ekvs_pkg::BK_DONE) |=> ov_reg)
        else $error("result not registered");
    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == ekvs_pkg::BK_IDLE)
        else $error("command taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && cur_reg.op == ekvs_pkg::OP_WRITE) |=> used_reg[$past(cur_reg.slot)])
        else $error("write did not mark slot");

endmodule

/* hdl/encrypted_key_value_store.sv */
// top level of the encrypted key-value store
`timescale 1ns / 1ps
// usage
// - in channel (in_valid/in_ready/in_data): one request word per set, get,
//   remove, has or clear. out channel (out_valid/out_ready/out_data): one
//   result word per request, in order.
// - cfg channel writes the two cipher key halves (index 0 low, 1 high);
//   write only while no request is outstanding.
// - the front end classifies a word against the slot table combinationally and
//   places it in a two-entry queue; it holds further words while an earlier
//   one is still queued or being executed, since its lookup needs the result.
// - set and get run the keystream unit: per value byte, sixteen fnv rounds
//   on one multiplier, then one xor; other kinds skip the keystream unit and
//   go straight to the result register.
// - reset empties all slots and clears both cipher key halves.
// - a stalled result waits in the output register; the back end takes no
//   further request until that result is taken.
module encrypted_key_value_store
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ekvs_pkg::req_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ekvs_pkg::rsp_t   out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [63:0]      cfg_data
);

    logic                         f_valid, f_ready, q_valid, q_ready, q_busy, b_busy;
    ekvs_pkg::cmd_t               f_cmd, q_cmd;
    logic [ekvs_pkg::ENTRIES-1:0] used;
    logic [63:0]                  keys [ekvs_pkg::ENTRIES];
    logic [3:0]                   lens [ekvs_pkg::ENTRIES];

    // front end
    ekvs_front u_front
    (
        .in_valid, .in_ready, .in_data,
        .slot_used(used), .slot_key(keys), .slot_length(lens),
        .hazard(q_busy || b_busy),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_cmd)
    );

    // queue
    ekvs_queue u_queue
    (
        .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd), .not_empty(q_busy)
    );

    // back end
    ekvs_back u_back
    (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_cmd),
        .slot_used(used), .slot_key(keys), .slot_length(lens),
        .busy(b_busy), .out_valid, .out_ready, .out_data
    );

endmodule
